/* hdl/rapg_pkg.sv */
// Shared types, widths, constants and helpers of the ring alpha pixel generator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rapg_pkg;

   localparam int FRAC_BITS = 16;
   localparam int MAX_DIM   = 4096;

   localparam int COORD_W = 12;
   localparam int DIM_W   = 13;
   localparam int ALPHA_W = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // centred coordinate path
   localparam int QUOT_W = FRAC_BITS + 2;
   localparam int MAG_W  = FRAC_BITS + 1;
   localparam int SQ_W   = 2 * MAG_W + 1;

   // square root path
   localparam int RAD_W       = SQ_W + 1;
   localparam int SQRT_ITERS  = RAD_W / 2;
   localparam int SQRT_ROOT_W = SQRT_ITERS;
   localparam int SQRT_REM_W  = SQRT_ROOT_W + 2;

   // ramp and smoothstep
   localparam int SCALED_W    = MAG_W + 7;
   localparam int PROD_W      = 2 * SCALED_W;
   localparam int RECIP_SHIFT = 27;
   localparam int KMUL_W      = MAG_W + 1;
   localparam int S_W         = MAG_W + 1;
   localparam int BYTE_PROD_W = MAG_W + 8;

   // pipeline shape
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES  = QUOT_W / STEPS_PER_STAGE;
   localparam int SQRT_STAGES = SQRT_ITERS / STEPS_PER_STAGE;
   localparam int ST_MAG      = DIV_STAGES;
   localparam int ST_SQ       = ST_MAG + 1;
   localparam int ST_SQRT0    = ST_SQ + 1;
   localparam int ST_DIFF     = ST_SQRT0 + SQRT_STAGES;
   localparam int ST_RECIP    = ST_DIFF + 1;
   localparam int ST_ALPHA    = ST_RECIP + 1;
   localparam int ST_ASQ      = ST_ALPHA + 1;
   localparam int ST_SMOOTH   = ST_ASQ + 1;
   localparam int ST_OUT      = ST_SMOOTH + 1;
   localparam int NUM_STAGES  = ST_OUT + 1;

   localparam logic [DIM_W-1:0]    MAX_DIM_V = DIM_W'(MAX_DIM);
   localparam logic [MAG_W-1:0]    ONE       = MAG_W'(1) << FRAC_BITS;
   localparam logic [MAG_W-1:0]    HALF      = MAG_W'(1) << (FRAC_BITS - 1);
   localparam logic [KMUL_W-1:0]   THREE_ONE = KMUL_W'(3) << FRAC_BITS;
   localparam logic [SCALED_W-1:0] SCALE_100 = SCALED_W'(100);
   // ceil(2^27 / 9): exact floor(n / 9) for n below 2^27
   localparam logic [SCALED_W-1:0] RECIP9    = SCALED_W'(14913081);
   localparam logic [DIM_W-1:0]    DIM_RESET = DIM_W'(64);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_INVERT_ALPHA = 2'd2
   } csr_index_type;

   // round the doubled quotient and fold it about the centre
   function automatic logic [MAG_W-1:0] centre_mag(input logic [QUOT_W-1:0] quot);
      logic [QUOT_W:0] sum;
      logic [MAG_W-1:0] q;
      sum = {1'b0, quot} + (QUOT_W + 1)'(1);
      // the halved quotient stays below 2^17 for every frame up to the maximum
      q   = sum[MAG_W:1];
      return (q >= ONE) ? (q - ONE) : (ONE - q);
   endfunction

endpackage

`default_nettype wire

/* hdl/rapg_div_lane.sv */
// Pipelined restoring divider for one axis: (2p+1) * 2^(F+1) / dim, two bits a stage.
// Depends on rapg_pkg.
`default_nettype none

module rapg_div_lane import rapg_pkg::*; (
   input  wire logic                  clock,
   input  wire logic [DIV_STAGES-1:0] stage_en,
   input  wire logic [COORD_W-1:0]    coord,
   input  wire logic [DIM_W-1:0]      dim,
   output logic      [QUOT_W-1:0]     quot
);

   logic [DIM_W-1:0]  rem_ff  [DIV_STAGES];
   logic [QUOT_W-1:0] quot_ff [DIV_STAGES];
   logic [DIM_W-1:0]  rem_in  [DIV_STAGES];
   logic [QUOT_W-1:0] quot_in [DIV_STAGES];

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
      logic [DIM_W-1:0]  rem_src;
      logic [QUOT_W-1:0] quot_src;

      if (j == 0) begin : g_first
         // the top quotient bits are zero since p < dim; start from p
         assign rem_src  = {1'b0, coord};
         assign quot_src = '0;
      end else begin : g_next
         assign rem_src  = rem_ff[j-1];
         assign quot_src = quot_ff[j-1];
      end

      always_comb begin
         logic [DIM_W-1:0]  r;
         logic [QUOT_W-1:0] q;
         r = rem_src;
         q = quot_src;
         for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            // only the first step brings in the set bit of 2p+1
            r = {r[DIM_W-2:0], (j == 0 && s == 0) ? 1'b1 : 1'b0};
            if (r >= dim) begin
               r = r - dim;
               q = {q[QUOT_W-2:0], 1'b1};
            end else begin
               q = {q[QUOT_W-2:0], 1'b0};
            end
         end
         rem_in[j]  = r;
         quot_in[j] = q;
      end

      always_ff @(posedge clock) begin
         if (stage_en[j]) begin
            rem_ff[j]  <= rem_in[j];
            quot_ff[j] <= quot_in[j];
         end
      end
   end

   assign quot = quot_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

/* hdl/rapg_sqrt_pipe.sv */
// Pipelined digit-by-digit integer square root (floor), two result bits a stage.
// Depends on rapg_pkg.
`default_nettype none

module rapg_sqrt_pipe import rapg_pkg::*; (
   input  wire logic                   clock,
   input  wire logic [SQRT_STAGES-1:0] stage_en,
   input  wire logic [SQ_W-1:0]        radicand,
   output logic      [MAG_W-1:0]       root
);

   logic [SQRT_REM_W-1:0]  rem_ff  [SQRT_STAGES];
   logic [SQRT_ROOT_W-1:0] root_ff [SQRT_STAGES];
   logic [RAD_W-1:0]       rad_ff  [SQRT_STAGES];
   logic [SQRT_REM_W-1:0]  rem_in  [SQRT_STAGES];
   logic [SQRT_ROOT_W-1:0] root_in [SQRT_STAGES];
   logic [RAD_W-1:0]       rad_in  [SQRT_STAGES];

   for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
      logic [SQRT_REM_W-1:0]  rem_src;
      logic [SQRT_ROOT_W-1:0] root_src;
      logic [RAD_W-1:0]       rad_src;

      if (j == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = {1'b0, radicand};
      end else begin : g_next
         assign rem_src  = rem_ff[j-1];
         assign root_src = root_ff[j-1];
         assign rad_src  = rad_ff[j-1];
      end

      always_comb begin
         logic [SQRT_REM_W-1:0]  r;
         logic [SQRT_ROOT_W-1:0] q;
         logic [RAD_W-1:0]       n;
         logic [SQRT_REM_W-1:0]  trial;
         r = rem_src;
         q = root_src;
         n = rad_src;
         for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            r     = {r[SQRT_REM_W-3:0], n[RAD_W-1 -: 2]};
            n     = {n[RAD_W-3:0], 2'b00};
            trial = {q, 2'b01};
            if (r >= trial) begin
               r = r - trial;
               q = {q[SQRT_ROOT_W-2:0], 1'b1};
            end else begin
               q = {q[SQRT_ROOT_W-2:0], 1'b0};
            end
         end
         rem_in[j]  = r;
         root_in[j] = q;
         rad_in[j]  = n;
      end

      always_ff @(posedge clock) begin
         if (stage_en[j]) begin
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
            rad_ff[j]  <= rad_in[j];
         end
      end
   end

   assign root = root_ff[SQRT_STAGES-1][MAG_W-1:0];

endmodule

`default_nettype wire

/* hdl/ring_alpha_pixel_generator_unit.sv */
// Top level of the ring alpha pixel generator: smoothstep radial ring alpha per pixel.
// Depends on rapg_pkg, rapg_div_lane and rapg_sqrt_pipe.
//
//   channel  direction  handshake            word
//   req_     in         req_valid/req_stall  pixel_x, pixel_y
//   rsp_     out        rsp_valid/rsp_stall  alpha_byte, coord_valid
//   csr_     in         csr_valid/csr_ready  csr_index, csr_data
//
// One word enters per clock while req_stall is low; each word passes through the
// nine divider stages, the nine square root stages and eight arithmetic stages.
// Each stage holds only while the stage after it is full and holding, so bubbles
// close up and input is taken while a finished word waits at the output.
// Reset (synchronous) empties the pipeline and restores 64 x 64, non-inverted.
`default_nettype none

module ring_alpha_pixel_generator_unit import rapg_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [COORD_W-1:0]    req_pixel_x,
   input  wire logic [COORD_W-1:0]    req_pixel_y,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [ALPHA_W-1:0]    rsp_alpha_byte,
   output logic                       rsp_coord_valid,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // configuration registers
   logic [DIM_W-1:0] width_ff, height_ff;
   logic             invert_ff;
   logic [DIM_W-1:0] width_eff, height_eff;

   // pipeline control: valid and in-frame flags travel with each word
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] cv_ff;
   logic [NUM_STAGES-1:0] stage_en;
   logic                  cv_in;

   // datapath
   logic [QUOT_W-1:0]   quot_u, quot_v;
   logic [MAG_W-1:0]    mag_u_ff, mag_v_ff;
   logic [2*MAG_W-1:0]  sq_u, sq_v;
   logic [SQ_W-1:0]     sq_in, sq_ff;
   logic [MAG_W-1:0]    root;
   logic [MAG_W-1:0]    diff;
   logic [SCALED_W-1:0] scaled_in, scaled_ff;
   logic [PROD_W-1:0]   prod_in, prod_ff;
   logic [PROD_W-RECIP_SHIFT:0] ramp_sum;
   logic [MAG_W-1:0]    a_in, a_ff, a_d_ff;
   logic [2*MAG_W-1:0]  asq_prod;
   logic [2*MAG_W:0]    asq_sum;
   logic [MAG_W-1:0]    a2_in, a2_ff;
   logic [KMUL_W-1:0]   kmul;
   logic [MAG_W+KMUL_W-1:0] smooth_prod;
   logic [MAG_W+KMUL_W:0] smooth_sum;
   logic [S_W-1:0]      s_in, s_ff;
   logic [MAG_W-1:0]    s_clamp, s_final;
   logic [BYTE_PROD_W-1:0] byte_prod;
   logic [ALPHA_W-1:0]  byte_in, byte_ff;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
         invert_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  width_ff  <= csr_data;
            CSR_FRAME_HEIGHT: height_ff <= csr_data;
            CSR_INVERT_ALPHA: invert_ff <= csr_data[0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // saturate oversize frames to the largest supported dimension
   assign width_eff  = (width_ff  > MAX_DIM_V) ? MAX_DIM_V : width_ff;
   assign height_eff = (height_ff > MAX_DIM_V) ? MAX_DIM_V : height_ff;

   // a zero dimension fails the compare on its own, so no separate check
   assign cv_in = ({1'b0, req_pixel_x} < width_eff) && ({1'b0, req_pixel_y} < height_eff);

   // ---------------- stage enables ----------------
   // advance a stage when it is empty or the stage after it advances
   always_comb begin
      stage_en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !vld_ff[i] || stage_en[i+1];
      end
   end

   assign req_stall = !stage_en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (stage_en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         cv_ff[0] <= cv_in;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (stage_en[i]) begin
            cv_ff[i] <= cv_ff[i-1];
         end
      end
   end

   // ---------------- centred coordinates: two divider lanes ----------------
   rapg_div_lane u_div_x (
      .clock    (clock),
      .stage_en (stage_en[DIV_STAGES-1:0]),
      .coord    (req_pixel_x),
      .dim      (width_eff),
      .quot     (quot_u)
   );

   rapg_div_lane u_div_y (
      .clock    (clock),
      .stage_en (stage_en[DIV_STAGES-1:0]),
      .coord    (req_pixel_y),
      .dim      (height_eff),
      .quot     (quot_v)
   );

   always_ff @(posedge clock) begin
      if (stage_en[ST_MAG]) begin
         mag_u_ff <= centre_mag(quot_u);
         mag_v_ff <= centre_mag(quot_v);
      end
   end

   // ---------------- radius squared ----------------
   assign sq_u  = mag_u_ff * mag_u_ff;
   assign sq_v  = mag_v_ff * mag_v_ff;
   assign sq_in = {1'b0, sq_u} + {1'b0, sq_v};

   always_ff @(posedge clock) begin
      if (stage_en[ST_SQ]) begin
         sq_ff <= sq_in;
      end
   end

   rapg_sqrt_pipe u_sqrt (
      .clock    (clock),
      .stage_en (stage_en[ST_SQRT0 +: SQRT_STAGES]),
      .radicand (sq_ff),
      .root     (root)
   );

   // ---------------- linear ramp (1 - r) / 0.18 ----------------
   // outside the unit circle the ramp is zero
   assign diff      = (root >= ONE) ? '0 : (ONE - root);
   assign scaled_in = SCALED_W'(diff) * SCALE_100;

   always_ff @(posedge clock) begin
      if (stage_en[ST_DIFF]) begin
         scaled_ff <= scaled_in;
      end
   end

   // divide by nine through the reciprocal
   assign prod_in = PROD_W'(scaled_ff) * PROD_W'(RECIP9);

   always_ff @(posedge clock) begin
      if (stage_en[ST_RECIP]) begin
         prod_ff <= prod_in;
      end
   end

   // round the doubled ramp down to F bits and clamp at one
   assign ramp_sum = {1'b0, prod_ff[PROD_W-1:RECIP_SHIFT]} + (PROD_W - RECIP_SHIFT + 1)'(1);
   assign a_in     = (ramp_sum[PROD_W-RECIP_SHIFT:1] > (PROD_W - RECIP_SHIFT)'(ONE))
                     ? ONE : ramp_sum[MAG_W:1];

   always_ff @(posedge clock) begin
      if (stage_en[ST_ALPHA]) begin
         a_ff <= a_in;
      end
   end

   // ---------------- smoothstep a*a*(3 - 2a) ----------------
   // keep the full product width before rounding back to F bits
   assign asq_prod = a_ff * a_ff;
   assign asq_sum  = {1'b0, asq_prod} + (2*MAG_W + 1)'(HALF);
   assign a2_in    = asq_sum[FRAC_BITS +: MAG_W];

   always_ff @(posedge clock) begin
      if (stage_en[ST_ASQ]) begin
         a2_ff  <= a2_in;
         a_d_ff <= a_ff;
      end
   end

   assign kmul        = THREE_ONE - {a_d_ff, 1'b0};
   assign smooth_prod = a2_ff * kmul;
   assign smooth_sum  = {1'b0, smooth_prod} + (MAG_W + KMUL_W + 1)'(HALF);
   assign s_in        = smooth_sum[FRAC_BITS +: S_W];

   always_ff @(posedge clock) begin
      if (stage_en[ST_SMOOTH]) begin
         s_ff <= s_in;
      end
   end

   // ---------------- clamp, invert, scale to a byte ----------------
   assign s_clamp   = (s_ff > S_W'(ONE)) ? ONE : s_ff[MAG_W-1:0];
   assign s_final   = invert_ff ? (ONE - s_clamp) : s_clamp;
   assign byte_prod = {s_final, 8'd0} - BYTE_PROD_W'(s_final) + BYTE_PROD_W'(HALF);
   // out-of-frame words carry a zero alpha
   assign byte_in   = cv_ff[ST_SMOOTH] ? byte_prod[FRAC_BITS +: ALPHA_W] : '0;

   always_ff @(posedge clock) begin
      if (stage_en[ST_OUT]) begin
         byte_ff <= byte_in;
      end
   end

   assign rsp_valid       = vld_ff[ST_OUT];
   assign rsp_alpha_byte  = byte_ff;
   assign rsp_coord_valid = cv_ff[ST_OUT];

endmodule

`default_nettype wire
